// ===== rtl/rdhs_pkg.sv =====
// ----------------------------------------------------------------------------
// rdhs_pkg
// Shared constants, state codes and types of the row density segmenter.
// ----------------------------------------------------------------------------
package rdhs_pkg;

    localparam int COORD_BITS = 12;
    localparam int PIX_W      = 8;
    localparam int PCT_W      = 7;
    localparam int SUM_W      = PIX_W + COORD_BITS;
    localparam int CMP_W      = SUM_W + PCT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENTER_PCT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXIT_PCT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_ROW   = 3'd5;

    localparam logic [COORD_BITS-1:0] RST_WIN_LEFT   = COORD_BITS'(0);
    localparam logic [COORD_BITS-1:0] RST_WIN_RIGHT  = COORD_BITS'(64);
    localparam logic [COORD_BITS-1:0] RST_MIN_LENGTH = COORD_BITS'(5);
    localparam logic [PCT_W-1:0]      RST_ENTER_PCT  = PCT_W'(60);
    localparam logic [PCT_W-1:0]      RST_EXIT_PCT   = PCT_W'(50);
    localparam logic [COORD_BITS-1:0] RST_STOP_ROW   = COORD_BITS'(5);

    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_INSIDE = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0]      pixel;
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic                  row_end;
        logic                  frame_start;
    } item_t;

    typedef struct packed {
        logic                  kind;
        logic [COORD_BITS-1:0] bottom_row;
        logic [COORD_BITS-1:0] top_row;
        logic [COORD_BITS-1:0] span;
        logic [COORD_BITS-1:0] bed_top;
        logic                  any_found;
        logic                  last_result;
    } result_t;

    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t data0;
        result_t data1;
    } push_t;

endpackage

// ===== rtl/rdhs_out_fifo.sv =====
// ----------------------------------------------------------------------------
// rdhs_out_fifo
// Result queue that takes up to two words per cycle and gives one.
// ----------------------------------------------------------------------------
module rdhs_out_fifo
    import rdhs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    input  logic    pop,
    output result_t rdata,
    output logic    valid,
    output logic    room2
);

    result_t                mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg;
    logic [FIFO_AW-1:0]     wr_ptr_next;
    logic [FIFO_AW-1:0]     rd_ptr_reg;
    logic [FIFO_AW-1:0]     rd_ptr_next;
    logic [FIFO_AW:0]       count_reg;
    logic [FIFO_AW:0]       count_next;
    logic [FIFO_AW-1:0]     wr_ptr_plus1;
    logic [FIFO_AW:0]       push_cnt;
    logic                   do_pop;

    assign valid        = (count_reg != '0);
    assign room2        = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign rdata        = mem[rd_ptr_reg];
    assign do_pop       = pop && valid;
    assign wr_ptr_plus1 = wr_ptr_reg + FIFO_AW'(1);

    always_comb
    begin
        push_cnt    = (FIFO_AW+1)'(push.push0) + (FIFO_AW+1)'(push.push1);
        wr_ptr_next = wr_ptr_reg + push_cnt[FIFO_AW-1:0];
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(do_pop);
        count_next  = count_reg + push_cnt - (FIFO_AW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            mem[wr_ptr_reg] <= push.data0;
        end
        if (push.push1)
        begin
            mem[wr_ptr_plus1] <= push.data1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/row_density_hysteresis_segmenter.sv =====
// ----------------------------------------------------------------------------
// row_density_hysteresis_segmenter
// Sums mask pixels of each row inside a column window and opens and closes
// segments by two density levels, reporting kept segments and a frame summary.
// ----------------------------------------------------------------------------
// Flow: a word is registered in the input stage and evaluated there once the
// output queue has room for two results; its results are queued and offered.
// Throughput: one word per cycle; the input stalls while the four-entry output
// queue has fewer than two free entries.
// Reset clears the segmenter state and the queue and loads default registers.
module row_density_hysteresis_segmenter
    import rdhs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel,
    input  logic [COORD_BITS-1:0] column,
    input  logic [COORD_BITS-1:0] row,
    input  logic                  row_end,
    input  logic                  frame_start,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  kind,
    output logic [COORD_BITS-1:0] bottom_row,
    output logic [COORD_BITS-1:0] top_row,
    output logic [COORD_BITS-1:0] span,
    output logic [COORD_BITS-1:0] bed_top,
    output logic                  any_found,
    output logic                  last_result
);

    logic [COORD_BITS-1:0]      win_left_reg;
    logic [COORD_BITS-1:0]      win_right_reg;
    logic [COORD_BITS-1:0]      min_length_reg;
    logic [PCT_W-1:0]           enter_pct_reg;
    logic [PCT_W-1:0]           exit_pct_reg;
    logic [COORD_BITS-1:0]      stop_row_reg;

    logic [CMP_W-1:0]           thr_enter_reg;
    logic [CMP_W-1:0]           thr_exit_reg;
    logic [CMP_W-1:0]           thr_enter_next;
    logic [CMP_W-1:0]           thr_exit_next;
    logic [COORD_BITS-1:0]      width;
    logic [PCT_W+COORD_BITS-1:0] enter_pw;
    logic [PCT_W+COORD_BITS-1:0] exit_pw;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    item_t                      s1_item_reg;

    logic [1:0]                 phase_reg;
    logic [1:0]                 phase_next;
    logic [SUM_W-1:0]           row_sum_reg;
    logic [SUM_W-1:0]           row_sum_next;
    logic [COORD_BITS-1:0]      open_bottom_reg;
    logic [COORD_BITS-1:0]      open_bottom_next;
    logic [COORD_BITS-1:0]      last_top_reg;
    logic [COORD_BITS-1:0]      last_top_next;
    logic                       seen_reg;
    logic                       seen_next;

    logic                       proc;
    logic                       room2;
    push_t                      push;
    result_t                    head;

    logic [1:0]                 ph_eff;
    logic [SUM_W-1:0]           sum_eff;
    logic [COORD_BITS-1:0]      bottom_eff;
    logic [COORD_BITS-1:0]      top_eff;
    logic                       seen_eff;
    logic                       win_ok;
    logic [SUM_W:0]             sum_add;
    logic [SUM_W-1:0]           sum_new;
    logic [CMP_W-1:0]           sum_x100;
    logic                       over_enter;
    logic                       over_exit;
    logic                       open_seg;
    logic [1:0]                 ph1;
    logic [1:0]                 ph2;
    logic [COORD_BITS-1:0]      bottom1;
    logic                       seen1;
    logic                       close_seg;
    logic [COORD_BITS-1:0]      seg_span;
    logic                       keep;
    logic                       summ;
    result_t                    seg_res;
    result_t                    sum_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= RST_WIN_LEFT;
            win_right_reg  <= RST_WIN_RIGHT;
            min_length_reg <= RST_MIN_LENGTH;
            enter_pct_reg  <= RST_ENTER_PCT;
            exit_pct_reg   <= RST_EXIT_PCT;
            stop_row_reg   <= RST_STOP_ROW;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WIN_LEFT:   win_left_reg   <= cfg_data;
                REG_WIN_RIGHT:  win_right_reg  <= cfg_data;
                REG_MIN_LENGTH: min_length_reg <= cfg_data;
                REG_ENTER_PCT:  enter_pct_reg  <= cfg_data[PCT_W-1:0];
                REG_EXIT_PCT:   exit_pct_reg   <= cfg_data[PCT_W-1:0];
                REG_STOP_ROW:   stop_row_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // The density levels are percent * 255 * window width, held in registers.
    always_comb
    begin
        width          = (win_right_reg > win_left_reg) ? (win_right_reg - win_left_reg)
                                                        : '0;
        enter_pw       = (PCT_W+COORD_BITS)'(enter_pct_reg) * (PCT_W+COORD_BITS)'(width);
        exit_pw        = (PCT_W+COORD_BITS)'(exit_pct_reg) * (PCT_W+COORD_BITS)'(width);
        thr_enter_next = {enter_pw, {PIX_W{1'b0}}} - CMP_W'(enter_pw);
        thr_exit_next  = {exit_pw, {PIX_W{1'b0}}} - CMP_W'(exit_pw);
    end

    always_ff @(posedge clk)
    begin
        thr_enter_reg <= thr_enter_next;
        thr_exit_reg  <= thr_exit_next;
    end

    assign proc     = s1_valid_reg && room2;
    assign in_stall = s1_valid_reg && !room2;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && !in_stall)
        begin
            s1_valid_next = 1'b1;
        end
        else if (proc)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_item_reg <= '{pixel: pixel, column: column, row: row,
                             row_end: row_end, frame_start: frame_start};
        end
    end

    always_comb
    begin
        ph_eff     = s1_item_reg.frame_start ? PH_SEARCH : phase_reg;
        sum_eff    = s1_item_reg.frame_start ? '0 : row_sum_reg;
        bottom_eff = s1_item_reg.frame_start ? '0 : open_bottom_reg;
        top_eff    = s1_item_reg.frame_start ? '0 : last_top_reg;
        seen_eff   = s1_item_reg.frame_start ? 1'b0 : seen_reg;

        win_ok  = (win_right_reg > win_left_reg) && (s1_item_reg.column >= win_left_reg)
                  && (s1_item_reg.column <= win_right_reg);
        sum_add = {1'b0, sum_eff} + (SUM_W+1)'(win_ok ? s1_item_reg.pixel : '0);
        sum_new = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

        sum_x100   = CMP_W'({sum_new, 6'b0}) + CMP_W'({sum_new, 5'b0})
                     + CMP_W'({sum_new, 2'b0});
        over_enter = sum_x100 > thr_enter_reg;
        over_exit  = sum_x100 > thr_exit_reg;

        open_seg  = (ph_eff == PH_SEARCH) && (s1_item_reg.row > stop_row_reg) && over_enter;
        ph1       = open_seg ? PH_INSIDE : ph_eff;
        bottom1   = open_seg ? s1_item_reg.row : bottom_eff;
        seen1     = open_seg || seen_eff;
        close_seg = (ph1 == PH_INSIDE) && (!over_exit || (s1_item_reg.row == '0));
        seg_span  = (bottom1 >= s1_item_reg.row) ? (bottom1 - s1_item_reg.row) : '0;
        keep      = close_seg && (seg_span >= min_length_reg);
        ph2       = close_seg ? PH_SEARCH : ph1;
        summ      = (ph2 == PH_SEARCH) && (s1_item_reg.row <= stop_row_reg);

        seg_res = '{kind: KIND_SEGMENT, bottom_row: bottom1, top_row: s1_item_reg.row,
                    span: seg_span, bed_top: '0, any_found: 1'b1, last_result: !summ};
        sum_res = '{kind: KIND_SUMMARY, bottom_row: '0, top_row: '0, span: '0,
                    bed_top: seen1 ? (close_seg ? s1_item_reg.row : top_eff) : '0,
                    any_found: seen1, last_result: 1'b1};

        phase_next       = phase_reg;
        row_sum_next     = row_sum_reg;
        open_bottom_next = open_bottom_reg;
        last_top_next    = last_top_reg;
        seen_next        = seen_reg;
        push             = '{push0: 1'b0, push1: 1'b0, data0: seg_res, data1: sum_res};

        if (proc)
        begin
            phase_next       = ph_eff;
            row_sum_next     = sum_eff;
            open_bottom_next = bottom_eff;
            last_top_next    = top_eff;
            seen_next        = seen_eff;
            if (ph_eff != PH_DONE)
            begin
                if (!s1_item_reg.row_end)
                begin
                    row_sum_next = sum_new;
                end
                else
                begin
                    row_sum_next     = '0;
                    open_bottom_next = bottom1;
                    seen_next        = seen1;
                    last_top_next    = close_seg ? s1_item_reg.row : top_eff;
                    phase_next       = summ ? PH_DONE : ph2;
                    push.push0       = keep || summ;
                    push.push1       = keep && summ;
                    push.data0       = keep ? seg_res : sum_res;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            phase_reg       <= PH_SEARCH;
            row_sum_reg     <= '0;
            open_bottom_reg <= '0;
            last_top_reg    <= '0;
            seen_reg        <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            phase_reg       <= phase_next;
            row_sum_reg     <= row_sum_next;
            open_bottom_reg <= open_bottom_next;
            last_top_reg    <= last_top_next;
            seen_reg        <= seen_next;
        end
    end

    rdhs_out_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (!out_stall),
        .rdata (head),
        .valid (out_valid),
        .room2 (room2)
    );

    assign kind        = head.kind;
    assign bottom_row  = head.bottom_row;
    assign top_row     = head.top_row;
    assign span        = head.span;
    assign bed_top     = head.bed_top;
    assign any_found   = head.any_found;
    assign last_result = head.last_result;

endmodule

// ===== rtl/rdhs_checker.sv =====
// ----------------------------------------------------------------------------
// rdhs_checker
// Port-level checks on the result words of the row density segmenter.
// ----------------------------------------------------------------------------
module rdhs_checker
    import rdhs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  kind,
    input logic [COORD_BITS-1:0] bottom_row,
    input logic [COORD_BITS-1:0] top_row,
    input logic [COORD_BITS-1:0] span,
    input logic [COORD_BITS-1:0] bed_top,
    input logic                  any_found,
    input logic                  last_result
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word withdrawn while stalled");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_SUMMARY) |-> last_result)
        else $error("frame summary is not the last word of its input");

    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_SUMMARY)
        |-> (bottom_row == '0) && (top_row == '0) && (span == '0))
        else $error("frame summary carries segment rows");

    a_segment_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_SEGMENT) |-> any_found && (bed_top == '0))
        else $error("segment word has a bad found flag or bed top");

    a_no_bed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_SUMMARY) && !any_found |-> (bed_top == '0))
        else $error("summary without a segment reports a bed top");

endmodule

bind row_density_hysteresis_segmenter rdhs_checker u_rdhs_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .bottom_row  (bottom_row),
    .top_row     (top_row),
    .span        (span),
    .bed_top     (bed_top),
    .any_found   (any_found),
    .last_result (last_result)
);

// ===== tb/sv/row_density_hysteresis_segmenter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row density segmenter testbench
// Streams mask pixel words into the segmenter, frame by frame, and predicts
// every kept segment and frame summary with a cycle-free model of the row
// sums and the two-level hysteresis. Directed frames cover the level
// boundaries, filtering, row zero, restarts, empty windows and sum
// saturation; random frames follow under changing register settings, with
// random idle bursts on both channels.
// ----------------------------------------------------------------------------
module row_density_hysteresis_segmenter_tb;
    import rdhs_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [COORD_BITS-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic                  row_end;
    logic                  frame_start;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  kind;
    logic [COORD_BITS-1:0] bottom_row;
    logic [COORD_BITS-1:0] top_row;
    logic [COORD_BITS-1:0] span;
    logic [COORD_BITS-1:0] bed_top;
    logic                  any_found;
    logic                  last_result;

    logic [COORD_BITS-1:0] cur_left    = RST_WIN_LEFT;
    logic [COORD_BITS-1:0] cur_right   = RST_WIN_RIGHT;
    logic [COORD_BITS-1:0] cur_min_len = RST_MIN_LENGTH;
    logic [PCT_W-1:0]      cur_enter   = RST_ENTER_PCT;
    logic [PCT_W-1:0]      cur_exit    = RST_EXIT_PCT;
    logic [COORD_BITS-1:0] cur_stop    = RST_STOP_ROW;

    logic [1:0]            trk_phase  = PH_SEARCH;
    logic [SUM_W-1:0]      row_acc    = '0;
    logic [COORD_BITS-1:0] open_row   = '0;
    logic [COORD_BITS-1:0] closed_row = '0;
    logic                  seg_seen   = 1'b0;

    result_t     pending_reports[$];
    int unsigned live_words   = 0;
    int unsigned reports_made = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;
    int unsigned in_gap_pct   = 25;
    int unsigned out_gap_pct  = 25;
    int unsigned stall_left   = 0;
    int unsigned col_lo       = 0;
    int unsigned col_hi       = 8;

    row_density_hysteresis_segmenter uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel       (pixel),
        .column      (column),
        .row         (row),
        .row_end     (row_end),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .bottom_row  (bottom_row),
        .top_row     (top_row),
        .span        (span),
        .bed_top     (bed_top),
        .any_found   (any_found),
        .last_result (last_result)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic bit above_level(logic [PCT_W-1:0] pct);
        longint unsigned width;
        width = (cur_right > cur_left) ? (64'(cur_right) - 64'(cur_left)) : 64'd0;
        return (64'd100 * 64'(row_acc)) > (64'(pct) * 64'd255 * width);
    endfunction

    function automatic void track_pixel(item_t w);
        result_t               seg_rep;
        result_t               sum_rep;
        bit                    have_seg;
        bit                    have_sum;
        logic [SUM_W:0]        grown;
        logic [COORD_BITS-1:0] rows_spanned;
        seg_rep  = '0;
        sum_rep  = '0;
        have_seg = 1'b0;
        have_sum = 1'b0;
        if (w.frame_start)
        begin
            trk_phase  = PH_SEARCH;
            row_acc    = '0;
            open_row   = '0;
            closed_row = '0;
            seg_seen   = 1'b0;
        end
        if (trk_phase == PH_DONE)
            return;
        live_words++;
        if (cur_right > cur_left && w.column >= cur_left && w.column <= cur_right)
        begin
            grown   = {1'b0, row_acc} + (SUM_W+1)'(w.pixel);
            row_acc = grown[SUM_W] ? {SUM_W{1'b1}} : grown[SUM_W-1:0];
        end
        if (!w.row_end)
            return;
        if (trk_phase == PH_SEARCH && w.row > cur_stop && above_level(cur_enter))
        begin
            trk_phase = PH_INSIDE;
            open_row  = w.row;
            seg_seen  = 1'b1;
        end
        if (trk_phase == PH_INSIDE && (!above_level(cur_exit) || w.row == '0))
        begin
            rows_spanned = (open_row >= w.row) ? open_row - w.row : '0;
            closed_row   = w.row;
            trk_phase    = PH_SEARCH;
            if (rows_spanned >= cur_min_len)
            begin
                have_seg           = 1'b1;
                seg_rep.kind       = KIND_SEGMENT;
                seg_rep.bottom_row = open_row;
                seg_rep.top_row    = w.row;
                seg_rep.span       = rows_spanned;
                seg_rep.any_found  = 1'b1;
            end
        end
        if (trk_phase == PH_SEARCH && w.row <= cur_stop)
        begin
            have_sum          = 1'b1;
            sum_rep.kind      = KIND_SUMMARY;
            sum_rep.bed_top   = seg_seen ? closed_row : '0;
            sum_rep.any_found = seg_seen;
            trk_phase         = PH_DONE;
        end
        row_acc = '0;
        if (have_seg)
        begin
            seg_rep.last_result = !have_sum;
            pending_reports.push_back(seg_rep);
            reports_made++;
        end
        if (have_sum)
        begin
            sum_rep.last_result = 1'b1;
            pending_reports.push_back(sum_rep);
            reports_made++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {kind, bottom_row, top_row, span, bed_top, any_found, last_result};
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word at %0t: kind=%0d bottom=%0d top=%0d",
                             $realtime, got.kind, got.bottom_row, got.top_row);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got.kind !== want.kind || got.bottom_row !== want.bottom_row ||
                    got.top_row !== want.top_row || got.span !== want.span ||
                    got.bed_top !== want.bed_top || got.any_found !== want.any_found ||
                    got.last_result !== want.last_result)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("Mismatch at %0t: expected kind=%0d bottom=%0d top=%0d ",
                               $realtime, want.kind, want.bottom_row, want.top_row);
                        $write("span=%0d bed=%0d any=%0d last=%0d, ",
                               want.span, want.bed_top, want.any_found, want.last_result);
                        $write("got kind=%0d bottom=%0d top=%0d ",
                               got.kind, got.bottom_row, got.top_row);
                        $display("span=%0d bed=%0d any=%0d last=%0d",
                                 got.span, got.bed_top, got.any_found, got.last_result);
                    end
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (out_gap_pct > 0 && $urandom_range(0, 99) < out_gap_pct)
        begin
            stall_left = $urandom_range(0, 10);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send_word(logic [PIX_W-1:0] pix, logic [COORD_BITS-1:0] col,
                             logic [COORD_BITS-1:0] row_idx, logic last_px, logic first_px);
        item_t w;
        w = {pix, col, row_idx, last_px, first_px};
        if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel       <= pix;
        column      <= col;
        row         <= row_idx;
        row_end     <= last_px;
        frame_start <= first_px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_pixel(w);
    endtask

    task automatic send_dot(logic [COORD_BITS-1:0] row_idx, logic [COORD_BITS-1:0] col,
                            logic [PIX_W-1:0] pix, logic first_px);
        send_word(pix, col, row_idx, 1'b1, first_px);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_WIN_LEFT:   cur_left    = value;
            REG_WIN_RIGHT:  cur_right   = value;
            REG_MIN_LENGTH: cur_min_len = value;
            REG_ENTER_PCT:  cur_enter   = value[PCT_W-1:0];
            REG_EXIT_PCT:   cur_exit    = value[PCT_W-1:0];
            REG_STOP_ROW:   cur_stop    = value;
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [COORD_BITS-1:0] left, logic [COORD_BITS-1:0] right,
                            logic [COORD_BITS-1:0] min_len, logic [COORD_BITS-1:0] enter,
                            logic [COORD_BITS-1:0] leave, logic [COORD_BITS-1:0] stop);
        settle();
        write_reg(REG_WIN_LEFT, left);
        write_reg(REG_WIN_RIGHT, right);
        write_reg(REG_MIN_LENGTH, min_len);
        write_reg(REG_ENTER_PCT, enter);
        write_reg(REG_EXIT_PCT, leave);
        write_reg(REG_STOP_ROW, stop);
        cfg_valid <= 1'b0;
    endtask

    function automatic int unsigned gap_choice();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 35;
        endcase
    endfunction

    task automatic random_frame();
        int unsigned      r;
        int unsigned      step;
        int unsigned      max_step;
        int unsigned      fill;
        int unsigned      rows_left;
        int unsigned      c;
        logic [PIX_W-1:0] pix;
        bit               first;
        if (cur_stop >= 12'd4095)
            r = 4095;
        else
            r = $urandom_range(int'(cur_stop) + 1, 4095);
        max_step  = (r - int'(cur_stop)) / 5 + 1;
        rows_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 32'd1 << 20;
        first     = 1'b1;
        do
        begin
            fill = $urandom_range(0, 6) * 100 / 6;
            for (c = col_lo; c <= col_hi; c++)
            begin
                if ($urandom_range(0, 7) == 0)
                    pix = PIX_W'($urandom_range(0, 255));
                else
                    pix = ($urandom_range(0, 99) < fill) ? 8'hFF : 8'h00;
                send_word(pix, COORD_BITS'(c), COORD_BITS'(r), c == col_hi, first);
                first = 1'b0;
            end
            rows_left--;
            step = $urandom_range(1, max_step);
            r    = (r > step) ? r - step : 0;
        end
        while (trk_phase != PH_DONE && rows_left != 0);
        if (trk_phase == PH_DONE && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 5))
                send_word(PIX_W'($urandom_range(0, 255)), COORD_BITS'($urandom_range(0, 4095)),
                          COORD_BITS'($urandom_range(0, 4095)), $urandom_range(0, 1) == 1,
                          1'b0);
    endtask

    task automatic noise_burst();
        int unsigned k;
        int unsigned n;
        int unsigned c;
        n = $urandom_range(20, 60);
        for (k = 0; k < n; k++)
        begin
            c = ($urandom_range(0, 1) == 0) ? $urandom_range(col_lo, col_hi)
                                            : $urandom_range(0, 4095);
            send_word(PIX_W'($urandom_range(0, 255)), COORD_BITS'(c),
                      COORD_BITS'($urandom_range(0, 4095)), $urandom_range(0, 3) == 0,
                      k == 0);
        end
    endtask

    task automatic test_hysteresis_rows();
        set_regs(12'd3, 12'd4, 12'd2, 12'd60, 12'd50, 12'd5);
        send_dot(12'd4095, 12'd3, 8'd255, 1'b1);
        send_dot(12'd4000, 12'd3, 8'd140, 1'b0);
        send_dot(12'd3999, 12'd4, 8'd100, 1'b0);
        send_dot(12'd3998, 12'd3, 8'd140, 1'b0);
        send_word(8'd255, 12'd0, 12'd50, 1'b0, 1'b0);
        send_word(8'd200, 12'd5, 12'd50, 1'b0, 1'b0);
        send_dot(12'd50, 12'd4, 8'd160, 1'b0);
        send_dot(12'd49, 12'd3, 8'd0, 1'b0);
        send_dot(12'd3, 12'd3, 8'd255, 1'b0);
        send_dot(12'd2, 12'd3, 8'd255, 1'b0);
        send_dot(12'd8, 12'd3, 8'd255, 1'b1);
        send_dot(12'd0, 12'd3, 8'd255, 1'b0);
        send_dot(12'd5, 12'd3, 8'd255, 1'b1);
        send_dot(12'd100, 12'd3, 8'd255, 1'b1);
        send_word(8'd255, 12'd3, 12'd90, 1'b0, 1'b1);
        send_dot(12'd90, 12'd4, 8'd255, 1'b0);
        send_dot(12'd80, 12'd3, 8'd0, 1'b0);
        send_dot(12'd1, 12'd3, 8'd0, 1'b0);
    endtask

    task automatic test_register_extremes();
        int unsigned c;
        set_regs(12'd3, 12'd4, 12'd0, 12'd10, 12'd90, 12'd5);
        send_dot(12'd40, 12'd3, 8'd200, 1'b1);
        send_dot(12'd20, 12'd3, 8'd255, 1'b0);
        send_dot(12'd35, 12'd3, 8'd0, 1'b0);
        send_dot(12'd5, 12'd3, 8'd0, 1'b0);

        set_regs(12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0);
        send_dot(12'd4095, 12'd4095, 8'd1, 1'b1);
        send_dot(12'd10, 12'd0, 8'd0, 1'b0);
        send_dot(12'd0, 12'd0, 8'd0, 1'b0);

        set_regs(12'd0, 12'd1, 12'd0, 12'd127, 12'd100, 12'd4095);
        send_dot(12'd4095, 12'd1, 8'd255, 1'b1);

        set_regs(12'd0, 12'd1, 12'd0, 12'd100, 12'd0, 12'd0);
        send_dot(12'd100, 12'd0, 8'd255, 1'b1);
        send_word(8'd1, 12'd1, 12'd99, 1'b0, 1'b0);
        send_dot(12'd99, 12'd0, 8'd255, 1'b0);
        send_dot(12'd0, 12'd1, 8'd255, 1'b0);

        set_regs(12'd0, 12'd1, 12'd0, 12'd127, 12'd127, 12'd0);
        send_dot(12'd50, 12'd0, 8'd255, 1'b1);
        send_dot(12'd0, 12'd0, 8'd0, 1'b0);

        set_regs(12'd20, 12'd30, 12'd0, 12'd50, 12'd50, 12'd5);
        for (c = 20; c <= 30; c++)
            send_word(8'd255, COORD_BITS'(c), 12'd60, c == 30, c == 20);
        settle();
        write_reg(REG_WIN_RIGHT, 12'd20);
        write_reg(REG_SPARE, 12'hFFF);
        cfg_valid <= 1'b0;
        send_dot(12'd59, 12'd20, 8'd255, 1'b0);
        send_dot(12'd40, 12'd25, 8'd255, 1'b0);
        send_dot(12'd2, 12'd20, 8'd255, 1'b0);
        settle();
        write_reg(REG_WIN_LEFT, 12'd4095);
        cfg_valid <= 1'b0;
        send_dot(12'd100, 12'd4095, 8'd255, 1'b1);
        send_dot(12'd0, 12'd4095, 8'd255, 1'b0);
    endtask

    task automatic test_sum_saturation();
        int unsigned pass;
        int unsigned k;
        in_gap_pct  = 0;
        out_gap_pct = 10;
        for (pass = 0; pass < 2; pass++)
        begin
            set_regs(12'd0, 12'd4095, 12'd0, (pass == 0) ? 12'd101 : 12'd100, 12'd0, 12'd5);
            for (k = 0; k < 4200; k++)
                send_word(8'd255, COORD_BITS'($urandom_range(0, 4095)), 12'd10,
                          k == 4199, k == 0);
            send_dot(12'd3, 12'd0, 8'd0, 1'b0);
        end
    endtask

    task automatic test_random_frames();
        int unsigned word_goal;
        int unsigned report_goal;
        int unsigned left;
        int unsigned right;
        int unsigned min_len;
        int unsigned enter;
        int unsigned leave;
        int unsigned stop;
        int unsigned lo_w;
        int unsigned hi_w;
        word_goal   = live_words + 1700;
        report_goal = reports_made + 60;
        while (live_words < word_goal || reports_made < report_goal)
        begin
            left  = ($urandom_range(0, 5) == 0) ? $urandom_range(4080, 4086)
                                                : $urandom_range(0, 40);
            right = left + $urandom_range(1, 8);
            if (left >= 4080 && $urandom_range(0, 1) == 0)
                right = 4095;
            if ($urandom_range(0, 11) == 0)
                right = left - $urandom_range(0, (left < 3) ? left : 3);
            case ($urandom_range(0, 11))
                0: min_len = 0;
                1: min_len = 4095;
                default: min_len = $urandom_range(0, 20);
            endcase
            if ($urandom_range(0, 7) == 0)
            begin
                enter = $urandom_range(0, 127);
                leave = $urandom_range(0, 127);
            end
            else
            begin
                enter = $urandom_range(30, 90);
                leave = $urandom_range(10, enter);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                enter = enter + ($urandom_range(0, 31) << PCT_W);
                leave = leave + ($urandom_range(0, 31) << PCT_W);
            end
            stop = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 300);
            lo_w   = (left < right) ? left : right;
            hi_w   = (left < right) ? right : left;
            col_lo = (lo_w >= 2) ? lo_w - 2 : 0;
            col_hi = (hi_w <= 4093) ? hi_w + 2 : 4095;
            set_regs(COORD_BITS'(left), COORD_BITS'(right), COORD_BITS'(min_len),
                     COORD_BITS'(enter), COORD_BITS'(leave), COORD_BITS'(stop));
            repeat ($urandom_range(1, 3))
            begin
                in_gap_pct  = gap_choice();
                out_gap_pct = gap_choice();
                if ($urandom_range(0, 7) == 0)
                    noise_burst();
                else
                    random_frame();
            end
        end
    endtask

    task automatic test_steady_stream();
        in_gap_pct  = 0;
        out_gap_pct = 0;
        repeat (3) random_frame();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_WIN_LEFT;
        cfg_data    = '0;
        in_valid    = 1'b0;
        pixel       = '0;
        column      = '0;
        row         = '0;
        row_end     = 1'b0;
        frame_start = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_hysteresis_rows();
        test_register_extremes();
        test_sum_saturation();
        test_random_frames();
        test_steady_stream();

        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rdhs_pkg.sv
rtl/rdhs_out_fifo.sv
rtl/row_density_hysteresis_segmenter.sv
rtl/rdhs_checker.sv
tb/sv/row_density_hysteresis_segmenter_tb.sv
